### rtl/core/lru_pr_pkg.sv
// Shared constants and types for the LRU page replacement core.
// Used by lru_pr_cell and lru_page_replacement_core; no dependencies.
`timescale 1ns / 1ps

package lru_pr_pkg;

  // Frame count and page width
  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 8;

  // Derived widths
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int RANK_W = FIDX_W;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [FIDX_W-1:0]    fidx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Word handed from cell to cell during the scan
  typedef struct packed {
    logic  hit;
    fidx_t hit_idx;
    rank_t hit_rank;
    logic  lru_ok;
    fidx_t lru_idx;
    rank_t lru_rank;
    page_t lru_page;
  } scan_t;

  // Update command broadcast to all cells
  typedef struct packed {
    logic              en;
    fidx_t             sel;
    logic              wr_page;
    page_t             page;
    logic [RANK_W:0]   thr;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_t;

endpackage

### rtl/core/lru_pr_cell.sv
// One page frame cell: page, valid bit and recency rank, plus one scan stage.
// Depends on lru_pr_pkg.
`timescale 1ns / 1ps

module lru_pr_cell (
  input  logic               clk,
  input  logic               rst,
  input  lru_pr_pkg::fidx_t  idx,
  input  lru_pr_pkg::cnt_t   active_n,
  input  lru_pr_pkg::page_t  req_page,
  input  lru_pr_pkg::scan_t  chain_in,
  output lru_pr_pkg::scan_t  chain_out,
  input  lru_pr_pkg::upd_t   upd
);

  lru_pr_pkg::page_t page;
  logic              valid;
  lru_pr_pkg::rank_t rank;

  lru_pr_pkg::scan_t scan_next;
  logic              active;
  logic              match;

  assign active = lru_pr_pkg::CNT_W'(idx) < active_n;
  assign match  = active && valid && (page == req_page);

  // Scan stage: first hit wins, strictly older rank replaces the LRU pick
  always_comb begin
    scan_next = chain_in;
    if (match && !chain_in.hit) begin
      scan_next.hit      = 1'b1;
      scan_next.hit_idx  = idx;
      scan_next.hit_rank = rank;
    end
    if (active && (!chain_in.lru_ok || rank > chain_in.lru_rank)) begin
      scan_next.lru_ok   = 1'b1;
      scan_next.lru_idx  = idx;
      scan_next.lru_rank = rank;
      scan_next.lru_page = page;
    end
  end

  always_ff @(posedge clk) begin
    chain_out <= scan_next;
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.sel == idx) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (valid && ({1'b0, rank} < upd.thr)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.wr_page && (upd.sel == idx)) begin
      page <= upd.page;
    end
  end

endmodule

### rtl/core/lru_page_replacement_core.sv
// LRU page replacement core: frame cell chain plus reference sequencer.
// The result is set by the scan word walking the cell chain one cell per cycle.
// A new reference is accepted only once the last one has been applied; a result
// may wait in the output register while the next reference is scanned.
// Reset (rst, synchronous): frames empty, ranks and fault count zero, 16 frames in use.
`timescale 1ns / 1ps

module lru_page_replacement_core (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  // reference channel
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] page_number,
  // result channel
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       hit,
  output logic [3:0] frame_slot,
  output logic       evicted_valid,
  output logic [7:0] evicted_page,
  output logic [15:0] fault_count
);

  localparam int FRAMES = lru_pr_pkg::FRAMES;

  lru_pr_pkg::state_t state, state_next;

  logic [lru_pr_pkg::CFG_W-1:0] frames_in_use;
  lru_pr_pkg::cnt_t              active_n;
  lru_pr_pkg::cnt_t              filled_count;
  logic [15:0]                   faults;
  logic [15:0]                   faults_inc;
  lru_pr_pkg::page_t             req_page;
  lru_pr_pkg::fidx_t             cnt;

  lru_pr_pkg::scan_t chain_in  [FRAMES];
  lru_pr_pkg::scan_t chain_out [FRAMES];
  lru_pr_pkg::scan_t tail;
  lru_pr_pkg::upd_t  upd;

  logic              req_acc;
  logic              out_free;
  logic              do_fill;
  lru_pr_pkg::fidx_t slot;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_data;
    end
  end

  // Clamp frame count to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      active_n = lru_pr_pkg::CNT_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      active_n = lru_pr_pkg::CNT_W'(FRAMES);
    end else begin
      active_n = lru_pr_pkg::CNT_W'(frames_in_use);
    end
  end

  assign req_stall = (state != lru_pr_pkg::ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Latch the referenced page
  always_ff @(posedge clk) begin
    if (req_acc) begin
      req_page <= page_number[lru_pr_pkg::PAGE_BITS-1:0];
    end
  end

  // Cell chain
  genvar gi;
  generate
    for (gi = 0; gi < FRAMES; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign chain_in[gi] = '0;
      end else begin : g_link
        assign chain_in[gi] = chain_out[gi-1];
      end
      lru_pr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .idx       (lru_pr_pkg::FIDX_W'(gi)),
        .active_n  (active_n),
        .req_page  (req_page),
        .chain_in  (chain_in[gi]),
        .chain_out (chain_out[gi]),
        .upd       (upd)
      );
    end
  endgenerate

  assign tail = chain_out[FRAMES-1];

  // Replacement decision from the chain tail
  assign do_fill    = !tail.hit && (filled_count < active_n);
  assign faults_inc = (faults == 16'hFFFF) ? faults : faults + 16'd1;

  always_comb begin
    if (tail.hit) begin
      slot = tail.hit_idx;
    end else if (do_fill) begin
      slot = filled_count[lru_pr_pkg::FIDX_W-1:0];
    end else begin
      slot = tail.lru_idx;
    end
  end

  // Sequencer next state and update command
  always_comb begin
    state_next  = state;
    upd.en      = 1'b0;
    upd.sel     = slot;
    upd.wr_page = !tail.hit;
    upd.page    = req_page;
    if (tail.hit) begin
      upd.thr = {1'b0, tail.hit_rank};
    end else if (do_fill) begin
      upd.thr = (lru_pr_pkg::RANK_W + 1)'(FRAMES);
    end else begin
      upd.thr = {1'b0, tail.lru_rank};
    end
    unique case (state)
      lru_pr_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_next = lru_pr_pkg::ST_SCAN;
        end
      end
      lru_pr_pkg::ST_SCAN: begin
        if (cnt == lru_pr_pkg::FIDX_W'(FRAMES - 1)) begin
          state_next = lru_pr_pkg::ST_UPD;
        end
      end
      lru_pr_pkg::ST_UPD: begin
        if (out_free) begin
          upd.en     = 1'b1;
          state_next = lru_pr_pkg::ST_IDLE;
        end
      end
      default: state_next = lru_pr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_pr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan cycle counter
  always_ff @(posedge clk) begin
    if (rst || state != lru_pr_pkg::ST_SCAN) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 1'b1;
    end
  end

  // Fill count and fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
      faults       <= '0;
    end else if (upd.en && !tail.hit) begin
      faults <= faults_inc;
      if (do_fill) begin
        filled_count <= filled_count + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd.en) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      hit           <= tail.hit;
      frame_slot    <= 4'(slot);
      evicted_valid <= !tail.hit && !do_fill;
      evicted_page  <= (!tail.hit && !do_fill) ? 8'(tail.lru_page) : 8'd0;
      fault_count   <= tail.hit ? faults : faults_inc;
    end
  end

  // Assertions
  a_no_hit_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && evicted_valid))
    else $error("hit result reports an eviction");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(filled_count) <= FRAMES)
    else $error("fill count beyond frame count");

  a_hit_active: assert property (@(posedge clk) disable iff (rst)
    (state == lru_pr_pkg::ST_UPD && tail.hit) |->
      (lru_pr_pkg::CNT_W'(tail.hit_idx) < active_n))
    else $error("hit in an inactive frame");

  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !hit) |-> (fault_count != 16'd0))
    else $error("miss result with zero fault count");

endmodule

### verif/lru_page_replacement_core_test.sv
// Self-checking testbench for lru_page_replacement_core: directed table, random
// reference streams and a short miss-only run, checked against table values or an
// in-bench LRU frame predictor. Depends on lru_pr_pkg and the core RTL only.
`timescale 1ns / 1ps

module lru_page_replacement_core_test;

  // Settle time after the last result before a register write or the end
  localparam int DRAIN_CYCLES = lru_pr_pkg::FRAMES + 8;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_WORDS  = 100;
  localparam int MISS_WORDS   = 30;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic              hit;
    lru_pr_pkg::fidx_t slot;
    logic              ev_vld;
    lru_pr_pkg::page_t ev_page;
    logic [15:0]       faults;
  } ref_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  value;
    logic        has_exp;
    ref_result_t exp;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic [7:0]  page_number;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        hit;
  logic [3:0]  frame_slot;
  logic        evicted_valid;
  logic [7:0]  evicted_page;
  logic [15:0] fault_count;

  lru_page_replacement_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .page_number   (page_number),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .hit           (hit),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, a private copy of the frame table
  logic [lru_pr_pkg::CFG_W-1:0] frames_cfg;
  lru_pr_pkg::page_t            frame_pg  [lru_pr_pkg::FRAMES];
  logic                         frame_vld [lru_pr_pkg::FRAMES];
  lru_pr_pkg::rank_t            frame_rank[lru_pr_pkg::FRAMES];
  int                           filled_n;
  logic [15:0]                  fault_tally;

  ref_result_t       expected_q[$];
  stim_row_t         dir_rows[$];
  int                error_count  = 0;
  int                results_seen = 0;
  int                stall_left   = 0;
  bit                no_gap;
  bit                drain_fast;
  lru_pr_pkg::page_t pool_base;

  function automatic int active_count();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > lru_pr_pkg::FRAMES) return lru_pr_pkg::FRAMES;
    return int'(frames_cfg);
  endfunction

  // Frame f becomes most recent; valid frames younger than old_rank age by one
  function automatic void make_recent(int f, int old_rank);
    for (int i = 0; i < lru_pr_pkg::FRAMES; i++) begin
      if (i != f && frame_vld[i] && int'(frame_rank[i]) < old_rank)
        frame_rank[i] = frame_rank[i] + 1'b1;
    end
    frame_rank[f] = '0;
  endfunction

  // One reference: lookup, fill or evict, and the result word it produces
  function automatic ref_result_t lru_lookup(lru_pr_pkg::page_t pg);
    ref_result_t res;
    int          n;
    int          slot;
    int          best;
    bit          found;
    n     = active_count();
    slot  = 0;
    found = 1'b0;
    res   = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_vld[i] && frame_pg[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      make_recent(slot, int'(frame_rank[slot]));
    end else begin
      if (filled_n < n) begin
        slot = filled_n;
        filled_n++;
        frame_vld[slot] = 1'b1;
        frame_pg[slot]  = pg;
        make_recent(slot, lru_pr_pkg::FRAMES);
      end else begin
        best = 0;
        for (int i = 1; i < n; i++)
          if (frame_rank[i] > frame_rank[best]) best = i;
        slot        = best;
        res.ev_vld  = 1'b1;
        res.ev_page = frame_pg[slot];
        frame_pg[slot] = pg;
        make_recent(slot, int'(frame_rank[slot]));
      end
      if (fault_tally != 16'hFFFF) fault_tally++;
    end
    res.hit    = found;
    res.slot   = slot[lru_pr_pkg::FIDX_W-1:0];
    res.faults = fault_tally;
    return res;
  endfunction

  function automatic ref_result_t mk(logic h, int s, logic ev, int evp, int flt);
    ref_result_t r;
    r.hit     = h;
    r.slot    = s[lru_pr_pkg::FIDX_W-1:0];
    r.ev_vld  = ev;
    r.ev_page = evp[lru_pr_pkg::PAGE_BITS-1:0];
    r.faults  = flt[15:0];
    return r;
  endfunction

  function automatic void add_row(row_kind_t kind, int value, bit has_exp,
                                  ref_result_t exp);
    stim_row_t row;
    row.kind    = kind;
    row.value   = value[7:0];
    row.has_exp = has_exp;
    row.exp     = exp;
    dir_rows.push_back(row);
  endfunction

  // Mostly pages near a per-phase base so hits and evictions both happen
  function automatic lru_pr_pkg::page_t pick_page();
    if ($urandom_range(0, 9) < 2) return lru_pr_pkg::page_t'($urandom_range(0, 255));
    return pool_base + lru_pr_pkg::page_t'($urandom_range(0, active_count() + 1));
  endfunction

  // Offer one word after a random gap; record its expectation once accepted
  task automatic send_page(input lru_pr_pkg::page_t pg, input bit has_exp,
                           input ref_result_t typed);
    int          gap;
    ref_result_t model_res;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid   <= 1'b1;
    page_number <= pg;
    do @(posedge clk); while (req_stall);
    model_res = lru_lookup(pg);
    expected_q.push_back(has_exp ? typed : model_res);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_frames(input logic [lru_pr_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    frames_cfg = v;
  endtask

  task automatic report(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result side: check accepted words, draw a stall count for the next one
  always @(posedge clk) begin
    ref_result_t exp_res;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, hit %0d slot %0d fault_count %0d",
                   $time, hit, frame_slot, fault_count);
          error_count++;
        end else begin
          exp_res = expected_q.pop_front();
          report("hit", exp_res.hit, hit);
          report("frame_slot", exp_res.slot, frame_slot);
          report("evicted_valid", exp_res.ev_vld, evicted_valid);
          report("evicted_page", exp_res.ev_page, evicted_page);
          report("fault_count", exp_res.faults, fault_count);
        end
        results_seen++;
        if (results_seen == HOLD_AT)
          stall_left = HOLD_CYCLES;
        else if (drain_fast || (results_seen / 150) % 4 == 3)
          stall_left = 0;
        else
          stall_left = $urandom_range(0, 9);
      end else if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  always @(negedge clk) begin
    rsp_stall <= !rst && (stall_left != 0);
  end

  // Main sequence
  initial begin
    logic [lru_pr_pkg::CFG_W-1:0] cfg_plan[RAND_PHASES];
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    req_valid   = 1'b0;
    page_number = '0;
    no_gap       = 1'b0;
    drain_fast   = 1'b0;
    pool_base    = '0;
    frames_cfg   = lru_pr_pkg::FRAMES_IN_USE_RESET;
    filled_n     = 0;
    fault_tally  = '0;
    for (int i = 0; i < lru_pr_pkg::FRAMES; i++) begin
      frame_pg[i]   = '0;
      frame_vld[i]  = 1'b0;
      frame_rank[i] = '0;
    end

    // Directed table: empty frames, extremes, shrink and regrow of active set
    add_row(ROW_REF, 8'h00, 1, mk(0, 0, 0, 0, 1));
    add_row(ROW_REF, 8'hFF, 1, mk(0, 1, 0, 0, 2));
    add_row(ROW_REF, 8'h00, 1, mk(1, 0, 0, 0, 2));
    add_row(ROW_REF, 8'hAA, 0, '0);
    add_row(ROW_REF, 8'h55, 0, '0);
    // one active frame: evictions from frame 0, upper frames not searched
    add_row(ROW_CFG, 1, 0, '0);
    add_row(ROW_REF, 8'h07, 1, mk(0, 0, 1, 8'h00, 5));
    add_row(ROW_REF, 8'hFF, 1, mk(0, 0, 1, 8'h07, 6));
    // zero acts as one frame
    add_row(ROW_CFG, 0, 0, '0);
    add_row(ROW_REF, 8'hFF, 1, mk(1, 0, 0, 0, 6));
    // out of range acts as all frames; duplicate page hits lowest frame
    add_row(ROW_CFG, 31, 0, '0);
    add_row(ROW_REF, 8'hFF, 1, mk(1, 0, 0, 0, 6));
    for (int p = 8'h10; p <= 8'h1B; p++) add_row(ROW_REF, p, 0, '0);
    add_row(ROW_REF, 8'h1C, 0, '0);
    add_row(ROW_REF, 8'hAA, 0, '0);
    add_row(ROW_REF, 8'h80, 0, '0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_frames(dir_rows[i].value[lru_pr_pkg::CFG_W-1:0]);
      else
        send_page(dir_rows[i].value, dir_rows[i].has_exp, dir_rows[i].exp);
    end

    // Random phases, each under its own frame count
    cfg_plan = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd8, 5'd5, 5'd17, 5'd3, 5'd0};
    cfg_plan[RAND_PHASES-1] = 5'($urandom_range(0, 31));
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_frames(cfg_plan[ph]);
      no_gap    = (ph == 2 || ph == 6);
      pool_base = lru_pr_pkg::page_t'($urandom_range(0, 255));
      for (int k = 0; k < PHASE_WORDS; k++)
        send_page(pick_page(), 1'b0, '0);
    end

    // One frame and two alternating pages: every reference a miss, back to back
    set_frames(5'd1);
    no_gap     = 1'b1;
    drain_fast = 1'b1;
    for (int k = 0; k < MISS_WORDS; k++)
      send_page(k[0] ? 8'h02 : 8'h01, 1'b0, '0);

    drain_results();
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lru_pr_pkg.sv
rtl/core/lru_pr_cell.sv
rtl/core/lru_page_replacement_core.sv
verif/lru_page_replacement_core_test.sv
